// ===== rtl/ffrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffrp_pkg
// Shared widths, register indexes and reset values for the rectangle placer.
// ----------------------------------------------------------------------------
package ffrp_pkg;

   localparam int DefGridW = 64;
   localparam int DefGridH = 64;

   // field widths
   localparam int DimW  = 7;
   localparam int PosW  = 6;
   localparam int CsrAW = 1;
   localparam int CsrDW = 7;

   // register indexes
   localparam logic [CsrAW-1:0] CsrStripWidth  = 1'b0;
   localparam logic [CsrAW-1:0] CsrStripHeight = 1'b1;

   localparam logic [DimW-1:0] StripReset = 7'd64;

endpackage
`default_nettype wire

// ===== rtl/first_fit_rectangle_placer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_rectangle_placer
// First-fit placement of rectangles on an occupancy bitmap held in RAM.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  req_    | in        | rect_width, rect_height, clear_first
//  rsp_    | out       | placed, dest_x, dest_y, used_height
//  csr_    | in        | strip_width, strip_height writes
//
//  A clear pass writes one row per cycle. Each candidate row y reads its
//  window of h rows, in a read state and an accumulate state per row, and ORs
//  them into a column mask; the decide state then picks the lowest free column,
//  and marking reads and rewrites each of the h rows of the placed span. After
//  reset a clear pass runs before the first transfer. A stalled result holds in
//  the output register; the next item waits until it leaves.
// ----------------------------------------------------------------------------
module first_fit_rectangle_placer #(
   parameter int GridW = ffrp_pkg::DefGridW,
   parameter int GridH = ffrp_pkg::DefGridH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // rect_width[6:0], rect_height[13:7], clear_first[14]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // placed[0], dest_x[6:1], dest_y[12:7], used_height[19:13]
   input  wire logic        csr_wr_en,
   input  wire logic [ffrp_pkg::CsrAW-1:0] csr_index,
   input  wire logic [ffrp_pkg::CsrDW-1:0] csr_wdata
);

   localparam int AW = $clog2(GridH);
   localparam int CW = ($clog2(GridH + 1) > ffrp_pkg::DimW) ? $clog2(GridH + 1) + 1
                                                              : ffrp_pkg::DimW + 1;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_PICK, S_DECIDE, S_MARK_RD, S_MARK_WR, S_DONE
   } state_type;

   state_type state_ff, after_clr_ff;
   logic [AW-1:0]       clr_ff;
   logic [ffrp_pkg::DimW-1:0] sw_cfg_ff, sh_cfg_ff;
   logic [CW-1:0]       w_ff, h_ff, sw_ff, sh_ff, y_ff, r_ff, top_ff, x_ff;
   logic [GridW-1:0]    acc_ff, mask_ff;
   logic                placed_ff, rsp_valid_ff;

   logic                ram_we;
   logic [AW-1:0]       ram_wa, ram_ra;
   logic [GridW-1:0]    ram_wd, ram_rd;

   ffrp_ram #(.Width(GridW), .Depth(GridH)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   // request fields
   logic [CW-1:0] req_w, req_h, cfg_sw, cfg_sh;
   logic          req_bad;
   assign req_w  = CW'(req_tdata[6:0]);
   assign req_h  = CW'(req_tdata[13:7]);
   assign cfg_sw = (CW'(sw_cfg_ff) > CW'(GridW)) ? CW'(GridW) : CW'(sw_cfg_ff);
   assign cfg_sh = (CW'(sh_cfg_ff) > CW'(GridH)) ? CW'(GridH) : CW'(sh_cfg_ff);
   assign req_bad = (req_w == '0) || (req_h == '0) || (req_w > cfg_sw) || (req_h > cfg_sh);

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;

   // read address: row y + r during scan, marking reads
   logic [CW-1:0] row_sum;
   assign row_sum = y_ff + r_ff;
   assign ram_ra  = row_sum[AW-1:0];

   // w ones from bit 0
   logic [GridW-1:0] base_mask;
   assign base_mask = (w_ff >= CW'(GridW)) ? '1 : (((GridW)'(1) << w_ff) - 1'b1);

   // columns at which a w-wide span starting there fits the strip and stays clear
   logic [GridW-1:0] fit_vec;
   always_comb begin
      fit_vec = '0;
      for (int x = 0; x < GridW; x++) begin
         fit_vec[x] = ((CW'(x) + w_ff) <= sw_ff) && ((acc_ff & (base_mask << x)) == '0);
      end
   end

   // lowest set bit of fit_vec
   logic [CW-1:0]  first_x;
   logic           any_fit;
   always_comb begin
      first_x = '0;
      any_fit = 1'b0;
      for (int x = GridW - 1; x >= 0; x--) begin
         if (fit_vec[x]) begin
            first_x = CW'(x);
            any_fit = 1'b1;
         end
      end
   end

   // span mask for the chosen column
   logic [GridW-1:0] span;
   assign span = base_mask << first_x;

   // ram write port
   always_comb begin
      ram_we = 1'b0;
      ram_wa = row_sum[AW-1:0];
      ram_wd = ram_rd | mask_ff;
      if (state_ff == S_CLEAR) begin
         ram_we = 1'b1;
         ram_wa = clr_ff;
         ram_wd = '0;
      end else if (state_ff == S_MARK_WR) begin
         ram_we = 1'b1;
      end
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         after_clr_ff <= S_IDLE;
         clr_ff       <= '0;
         top_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         placed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sw_cfg_ff    <= ffrp_pkg::StripReset;
         sh_cfg_ff    <= ffrp_pkg::StripReset;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               ffrp_pkg::CsrStripWidth:  sw_cfg_ff <= csr_wdata;
               ffrp_pkg::CsrStripHeight: sh_cfg_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(GridH - 1)) begin
                  clr_ff   <= '0;
                  state_ff <= after_clr_ff;
               end
            end
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  w_ff      <= req_w;
                  h_ff      <= req_h;
                  sw_ff     <= cfg_sw;
                  sh_ff     <= cfg_sh;
                  y_ff      <= '0;
                  r_ff      <= '0;
                  x_ff      <= '0;
                  acc_ff    <= '0;
                  placed_ff <= 1'b0;
                  if (req_tdata[14]) begin
                     // clear pass first, then scan or report
                     top_ff       <= '0;
                     state_ff     <= S_CLEAR;
                     after_clr_ff <= req_bad ? S_DONE : S_SCAN;
                  end else if (req_bad) begin
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // read issued for row y+r; data arrives next cycle
               state_ff <= S_PICK;
            end
            S_PICK: begin
               acc_ff <= acc_ff | ram_rd;
               if (r_ff + 1'b1 < h_ff) begin
                  r_ff     <= r_ff + 1'b1;
                  state_ff <= S_SCAN;
               end else begin
                  r_ff     <= '0;
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               // window complete: pick column, read of row y issued here
               if (any_fit) begin
                  x_ff      <= first_x;
                  mask_ff   <= span;
                  placed_ff <= 1'b1;
                  state_ff  <= S_MARK_WR;
                  if (top_ff < y_ff + h_ff) top_ff <= y_ff + h_ff;
               end else if (y_ff + h_ff + 1'b1 <= sh_ff) begin
                  y_ff     <= y_ff + 1'b1;
                  acc_ff   <= '0;
                  state_ff <= S_SCAN;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_MARK_RD: begin
               state_ff <= S_MARK_WR;
            end
            S_MARK_WR: begin
               if (r_ff + 1'b1 < h_ff) begin
                  r_ff     <= r_ff + 1'b1;
                  state_ff <= S_MARK_RD;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, top_ff[6:0],
                        placed_ff ? y_ff[5:0] : 6'd0,
                        placed_ff ? x_ff[5:0] : 6'd0,
                        placed_ff};

   // assertions
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !rsp_valid_ff)
      else $error("request accepted while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_top_range: assert property (@(posedge clock) disable iff (reset)
      top_ff <= CW'(GridH))
      else $error("used height out of range");

endmodule
`default_nettype wire

// ===== rtl/ffrp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffrp_ram
// Generic simple dual-port RAM with one write port and registered read data.
// ----------------------------------------------------------------------------
module ffrp_ram #(
   parameter int Width = 64,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== dv/first_fit_rectangle_placer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_rectangle_placer_test
// Self-checking bench: rectangles go in over the req stream, a local
// first-fit grid model predicts each placement, and every rsp transfer is
// compared field by field under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module first_fit_rectangle_placer_test;

   localparam int GridW = 64;
   localparam int GridH = 64;
   localparam int CycleLimit = 4000000;
   localparam int DimW  = ffrp_pkg::DimW;
   localparam int PosW  = ffrp_pkg::PosW;
   localparam int CsrAW = ffrp_pkg::CsrAW;
   localparam int CsrDW = ffrp_pkg::CsrDW;

   typedef struct {
      logic            placed;
      logic [PosW-1:0] dest_x;
      logic [PosW-1:0] dest_y;
      logic [DimW-1:0] used_height;
   } placement_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;
   logic              csr_wr_en = 1'b0;
   logic [CsrAW-1:0]  csr_index = '0;
   logic [CsrDW-1:0]  csr_wdata = '0;

   // model state of the grid and strip
   logic [GridW-1:0]  grid_rows [GridH];
   logic [DimW-1:0]   grid_top;
   logic [DimW-1:0]   strip_w_reg;
   logic [DimW-1:0]   strip_h_reg;

   placement_type     pending_placements[$];
   int                fail_count = 0;
   int                cycle_count = 0;
   int                rsp_hold_cycles = 0;
   bit                long_hold_req = 1'b0;
   bit                long_hold_ack = 1'b0;

   first_fit_rectangle_placer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // first-fit placement on the model grid
   function automatic placement_type place_rect(logic [DimW-1:0] w, logic [DimW-1:0] h,
                                                logic clr);
      placement_type    res;
      int               sw, sh, x, y, r;
      logic [GridW-1:0] span;
      bit               fits, done;
      res = '{placed: 1'b0, dest_x: '0, dest_y: '0, used_height: '0};
      sw = (strip_w_reg > GridW) ? GridW : int'(strip_w_reg);
      sh = (strip_h_reg > GridH) ? GridH : int'(strip_h_reg);
      done = 1'b0;
      if (clr) begin
         for (r = 0; r < GridH; r++) grid_rows[r] = '0;
         grid_top = '0;
      end
      if (w != 0 && h != 0 && w <= sw && h <= sh) begin
         for (y = 0; y + h <= sh && !done; y++) begin
            for (x = 0; x + w <= sw && !done; x++) begin
               span = ((w >= GridW) ? {GridW{1'b1}} : ((64'd1 << w) - 64'd1)) << x;
               fits = 1'b1;
               for (r = 0; r < h; r++)
                  if ((grid_rows[y + r] & span) != 0) fits = 1'b0;
               if (fits) begin
                  for (r = 0; r < h; r++) grid_rows[y + r] |= span;
                  if (grid_top < y + h) grid_top = DimW'(y + h);
                  res.placed = 1'b1;
                  res.dest_x = PosW'(x);
                  res.dest_y = PosW'(y);
                  done = 1'b1;
               end
            end
         end
      end
      res.used_height = grid_top;
      return res;
   endfunction

   // sender gap: mostly none, some short, a few long
   task automatic sender_gap();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 55) return;
      n = (pick < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // one rectangle transfer, prediction taken at acceptance
   task automatic send_rect(logic [DimW-1:0] w, logic [DimW-1:0] h, logic clr);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, clr, h, w};
      do @(posedge clock); while (!req_tready);
      pending_placements.push_back(place_rect(w, h, clr));
      sender_gap();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrAW-1:0] idx, logic [CsrDW-1:0] val);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == ffrp_pkg::CsrStripWidth) strip_w_reg = val;
      else strip_h_reg = val;
      @(posedge clock);
   endtask

   // result checking
   always @(posedge clock) begin
      placement_type exp_p;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_placements.size() == 0) begin
            $error("result transfer with no expectation: %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_p = pending_placements.pop_front();
            if (rsp_tdata[0] !== exp_p.placed) begin
               $error("placed: expected %0d, got %0d", exp_p.placed, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[6:1] !== exp_p.dest_x) begin
               $error("dest_x: expected %0d, got %0d", exp_p.dest_x, rsp_tdata[6:1]);
               fail_count++;
            end
            if (rsp_tdata[12:7] !== exp_p.dest_y) begin
               $error("dest_y: expected %0d, got %0d", exp_p.dest_y, rsp_tdata[12:7]);
               fail_count++;
            end
            if (rsp_tdata[19:13] !== exp_p.used_height) begin
               $error("used_height: expected %0d, got %0d", exp_p.used_height,
                      rsp_tdata[19:13]);
               fail_count++;
            end
         end
      end
   end

   // receiver stalls, with a long hold-off on request
   always @(posedge clock) begin
      int pick;
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (long_hold_req != long_hold_ack) begin
         long_hold_ack   <= long_hold_req;
         rsp_hold_cycles <= 400;
         rsp_tready      <= 1'b0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70) rsp_tready <= 1'b1;
         else begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles <= (pick < 96) ? $urandom_range(0, 3) : $urandom_range(10, 60);
         end
      end
   end

   // extremes on the reset-sized strip
   task automatic test_directed_full_strip();
      send_rect(7'd64, 7'd64, 1'b1);
      send_rect(7'd1, 7'd1, 1'b0);    // grid full
      send_rect(7'd1, 7'd1, 1'b1);
      send_rect(7'd63, 7'd1, 1'b0);
      send_rect(7'd1, 7'd64, 1'b0);
      send_rect(7'd0, 7'd5, 1'b0);    // zero width
      send_rect(7'd5, 7'd0, 1'b0);    // zero height
      send_rect(7'd65, 7'd1, 1'b0);   // wider than strip
      send_rect(7'd127, 7'd127, 1'b0);
      send_rect(7'd64, 7'd63, 1'b1);
      send_rect(7'd64, 7'd1, 1'b0);
      send_rect(7'd32, 7'd16, 1'b1);
      send_rect(7'd32, 7'd16, 1'b0);
      send_rect(7'd42, 7'd85, 1'b0);
   endtask

   // tiny, zero-sized and oversized strips
   task automatic test_strip_limits();
      write_csr(ffrp_pkg::CsrStripWidth, 7'd1);
      write_csr(ffrp_pkg::CsrStripHeight, 7'd1);
      send_rect(7'd1, 7'd1, 1'b1);
      send_rect(7'd1, 7'd1, 1'b0);
      send_rect(7'd2, 7'd1, 1'b1);
      write_csr(ffrp_pkg::CsrStripWidth, 7'd0);
      send_rect(7'd1, 7'd1, 1'b1);
      write_csr(ffrp_pkg::CsrStripWidth, 7'd127);
      write_csr(ffrp_pkg::CsrStripHeight, 7'd127);
      send_rect(7'd64, 7'd2, 1'b0);   // grid emptied by the clear passes above; oversized strip clamps to the grid
      send_rect(7'd64, 7'd64, 1'b0);
      // shrink strip over a used grid
      write_csr(ffrp_pkg::CsrStripWidth, 7'd8);
      write_csr(ffrp_pkg::CsrStripHeight, 7'd8);
      send_rect(7'd3, 7'd3, 1'b0);
   endtask

   // random strips and rectangles, mostly fitting shapes
   task automatic test_random_packing(int n_items);
      int k;
      int sw, sh;
      logic [DimW-1:0] w, h;
      for (k = 0; k < n_items; k++) begin
         if (k % 20 == 0) begin
            sw = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 127)
                                             : $urandom_range(2, 16);
            sh = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 127)
                                             : $urandom_range(2, 16);
            write_csr(ffrp_pkg::CsrStripWidth, CsrDW'(sw));
            write_csr(ffrp_pkg::CsrStripHeight, CsrDW'(sh));
         end
         if ($urandom_range(0, 19) == 0) begin
            w = DimW'($urandom_range(0, 127));
            h = DimW'($urandom_range(0, 127));
         end else begin
            w = DimW'($urandom_range(1, (sw > 64 ? 64 : sw) / 2 + 1));
            h = DimW'($urandom_range(1, (sh > 64 ? 64 : sh) / 2 + 1));
         end
         send_rect(w, h, ($urandom_range(0, 9) == 0) || (k % 20 == 0));
      end
   endtask

   // long receiver hold-off while items keep coming
   task automatic test_backpressure();
      int k;
      write_csr(ffrp_pkg::CsrStripWidth, 7'd8);
      write_csr(ffrp_pkg::CsrStripHeight, 7'd8);
      long_hold_req = !long_hold_req;
      wait (long_hold_ack == long_hold_req);
      for (k = 0; k < 6; k++) send_rect(7'd2, 7'd2, k == 0);
      wait_drained();
      for (k = 0; k < 4; k++) send_rect(7'd3, 7'd1, 1'b0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int r = 0; r < GridH; r++) grid_rows[r] = '0;
      grid_top = '0;
      strip_w_reg = ffrp_pkg::StripReset;
      strip_h_reg = ffrp_pkg::StripReset;
      test_directed_full_strip();
      test_strip_limits();
      test_backpressure();
      test_random_packing(110);
      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ffrp_pkg.sv
rtl/ffrp_ram.sv
rtl/first_fit_rectangle_placer.sv
dv/first_fit_rectangle_placer_test.sv
